>>> sv/pip_pkg.sv
package pip_pkg;

    // command codes of an input transaction
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    localparam int unsigned EPS_W    = 16;
    localparam int unsigned IN_W     = 32;
    localparam int unsigned TOTAL_W  = 7;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd7;

endpackage

>>> sv/point_in_polygon_test.sv
// channel   direction  handshake            payload
// input     in         i_valid / o_ready    i_cmd, i_coord_x, i_coord_y
// result    out        o_valid / i_ready    o_inside_res, o_vertex_total,
//                                           o_store_full, o_too_few
// config    in         i_cfg_we             i_cfg_wdata (nudge_eps)
//
// an accepted transaction is registered into the queue before it can reach the queue head.
// clear, append, unused commands and short queries give their result at the
// edge that takes them from the queue; a query with n >= 3 vertices gives it
// once the sequencer has loaded the closing vertex (fetch, load) and then, per
// edge, done a memory read, relative/nudge, both products and a compare.
// reset is synchronous active low; vertex memory is not cleared, only the count.
// a two-entry queue takes new transactions while it has room, also while a query
// runs or a result waits; the back end takes nothing new until its result is accepted.
module point_in_polygon_test
    import pip_pkg::*;
#(
    parameter int unsigned MAX_VERTICES = 64,
    parameter int unsigned COORD_WIDTH  = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_cmd,
    input  logic signed [IN_W-1:0] i_coord_x,
    input  logic signed [IN_W-1:0] i_coord_y,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic                   o_inside_res,
    output logic [TOTAL_W-1:0]     o_vertex_total,
    output logic                   o_store_full,
    output logic                   o_too_few,
    input  logic                   i_cfg_we,
    input  logic [EPS_W-1:0]       i_cfg_wdata
);

    logic [EPS_W-1:0]                  r_nudge_eps;
    logic                              q_valid, q_pop;
    t_cmd                              q_cmd;
    logic signed [COORD_WIDTH-1:0]     q_x, q_y;
    logic [$clog2(MAX_VERTICES+1)-1:0] count;

    // tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nudge_eps <= EPS_RESET;
        end else if (i_cfg_we) begin
            r_nudge_eps <= i_cfg_wdata;
        end
    end

    pip_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_cmd     (i_cmd),
        .i_coord_x (i_coord_x),
        .i_coord_y (i_coord_y),
        .o_q_valid (q_valid),
        .i_q_pop   (q_pop),
        .o_q_cmd   (q_cmd),
        .o_q_x     (q_x),
        .o_q_y     (q_y)
    );

    pip_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_nudge_eps    (r_nudge_eps),
        .i_q_valid      (q_valid),
        .o_q_pop        (q_pop),
        .i_q_cmd        (q_cmd),
        .i_q_x          (q_x),
        .i_q_y          (q_y),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_inside_res   (o_inside_res),
        .o_vertex_total (o_vertex_total),
        .o_store_full   (o_store_full),
        .o_too_few      (o_too_few),
        .o_count        (count)
    );

    // vertex count never passes capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= ($clog2(MAX_VERTICES+1))'(MAX_VERTICES))
        else $error("vertex count above capacity");

    // a too-few result never reports inside
    a_few_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_too_few |-> !o_inside_res)
        else $error("too_few with inside set");

    // a dropped append only happens with a full store
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_store_full |-> count == ($clog2(MAX_VERTICES+1))'(MAX_VERTICES))
        else $error("store_full while store not full");

    // at most one flag per result
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $countones({o_inside_res, o_store_full, o_too_few}) <= 1)
        else $error("conflicting result flags");

endmodule

>>> sv/pip_ram.sv
module pip_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> sv/pip_front.sv
module pip_front
    import pip_pkg::*;
#(
    parameter int unsigned COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_cmd,
    input  logic signed [IN_W-1:0]        i_coord_x,
    input  logic signed [IN_W-1:0]        i_coord_y,
    output logic                          o_q_valid,
    input  logic                          i_q_pop,
    output t_cmd                          o_q_cmd,
    output logic signed [COORD_WIDTH-1:0] o_q_x,
    output logic signed [COORD_WIDTH-1:0] o_q_y
);

    localparam int unsigned DW = 2 + 2 * COORD_WIDTH;

    logic [DW-1:0] r_data [2];
    logic [1:0]    r_cnt;
    logic          r_wptr;
    logic          r_rptr;
    logic [DW-1:0] n_item;
    logic          push;

    // wrap coordinates to the internal width and pack the transaction
    always_comb begin
        n_item = {i_cmd, COORD_WIDTH'(i_coord_x), COORD_WIDTH'(i_coord_y)};
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = t_cmd'(r_data[r_rptr][DW-1 -: 2]);
    assign o_q_x     = r_data[r_rptr][2*COORD_WIDTH-1 -: COORD_WIDTH];
    assign o_q_y     = r_data[r_rptr][COORD_WIDTH-1:0];

    // two-entry queue toward the execution side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_q_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
        if (push) begin
            r_data[r_wptr] <= n_item;
        end
    end

endmodule

>>> sv/pip_back.sv
module pip_back
    import pip_pkg::*;
#(
    parameter int unsigned MAX_VERTICES = 64,
    parameter int unsigned COORD_WIDTH  = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [EPS_W-1:0]                 i_nudge_eps,
    input  logic                             i_q_valid,
    output logic                             o_q_pop,
    input  t_cmd                             i_q_cmd,
    input  logic signed [COORD_WIDTH-1:0]    i_q_x,
    input  logic signed [COORD_WIDTH-1:0]    i_q_y,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_inside_res,
    output logic [TOTAL_W-1:0]               o_vertex_total,
    output logic                             o_store_full,
    output logic                             o_too_few,
    output logic [$clog2(MAX_VERTICES+1)-1:0] o_count
);

    localparam int unsigned AW    = $clog2(MAX_VERTICES);
    localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int unsigned RW    = COORD_WIDTH + 1;
    localparam int unsigned PW    = 2 * RW;

    typedef enum logic [2:0] {S_IDLE, S_FETCH, S_LOAD, S_MUL, S_CMP} t_state;

    t_state                  r_state;
    logic [CNT_W-1:0]        r_count;
    logic [AW-1:0]           r_idx;
    logic                    r_first;
    logic                    r_odd;
    logic signed [RW-1:0]    r_qx, r_qy;
    logic signed [RW-1:0]    r_x0, r_y0, r_x1, r_y1;
    logic signed [PW-1:0]    r_p1, r_p2;

    logic                        ram_we;
    logic [2*COORD_WIDTH-1:0]    ram_rdata;
    logic signed [COORD_WIDTH-1:0] vx, vy;
    logic signed [RW-1:0]        rel_x, rel_y, ry_mag, ry_nudged;
    logic                        straddle, xp0, xp1, toggle;
    logic [AW-1:0]               last_idx;

    assign o_count  = r_count;
    assign last_idx = AW'(r_count - CNT_W'(1));
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid && !o_valid;
    assign ram_we   = o_q_pop && (i_q_cmd == CMD_APPEND)
                      && (r_count < CNT_W'(MAX_VERTICES));

    pip_ram #(
        .WIDTH (2 * COORD_WIDTH),
        .DEPTH (MAX_VERTICES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_q_x, i_q_y}),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // vertex relative to the query point, small y forced to minus tolerance
    always_comb begin
        vx        = ram_rdata[2*COORD_WIDTH-1 -: COORD_WIDTH];
        vy        = ram_rdata[COORD_WIDTH-1:0];
        rel_x     = RW'(vx) - r_qx;
        rel_y     = RW'(vy) - r_qy;
        ry_mag    = (rel_y < 0) ? -rel_y : rel_y;
        ry_nudged = ($unsigned(ry_mag) < RW'(i_nudge_eps))
                    ? -$signed(RW'(i_nudge_eps)) : rel_y;
    end

    // crossing decision for the edge held in the prev/cur registers
    always_comb begin
        straddle = ((r_y0 < 0) && (r_y1 > 0)) || ((r_y0 > 0) && (r_y1 < 0));
        xp0      = (r_x0 > 0);
        xp1      = (r_x1 > 0);
        toggle   = straddle && ((xp0 && xp1) || ((xp0 || xp1)
                   && (((r_y1 > r_y0) && (r_p1 > r_p2))
                       || ((r_y1 < r_y0) && (r_p1 < r_p2)))));
    end

    // command sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        o_inside_res <= 1'b0;
                        case (i_q_cmd)
                            CMD_CLEAR: begin
                                r_count        <= '0;
                                o_vertex_total <= '0;
                                o_store_full   <= 1'b0;
                                o_too_few      <= 1'b0;
                                o_valid        <= 1'b1;
                            end
                            CMD_APPEND: begin
                                o_too_few <= 1'b0;
                                o_valid   <= 1'b1;
                                if (ram_we) begin
                                    r_count        <= r_count + CNT_W'(1);
                                    o_vertex_total <= TOTAL_W'(r_count + CNT_W'(1));
                                    o_store_full   <= 1'b0;
                                end else begin
                                    o_vertex_total <= TOTAL_W'(r_count);
                                    o_store_full   <= 1'b1;
                                end
                            end
                            CMD_QUERY: begin
                                o_store_full   <= 1'b0;
                                o_vertex_total <= TOTAL_W'(r_count);
                                if (r_count < CNT_W'(3)) begin
                                    o_too_few <= 1'b1;
                                    o_valid   <= 1'b1;
                                end else begin
                                    o_too_few <= 1'b0;
                                    r_qx      <= RW'(i_q_x);
                                    r_qy      <= RW'(i_q_y);
                                    r_idx     <= last_idx;
                                    r_first   <= 1'b1;
                                    r_odd     <= 1'b0;
                                    r_state   <= S_FETCH;
                                end
                            end
                            default: begin
                                o_vertex_total <= TOTAL_W'(r_count);
                                o_store_full   <= 1'b0;
                                o_too_few      <= 1'b0;
                                o_valid        <= 1'b1;
                            end
                        endcase
                    end
                end
                S_FETCH: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (r_first) begin
                        r_x0    <= rel_x;
                        r_y0    <= ry_nudged;
                        r_first <= 1'b0;
                        r_idx   <= '0;
                        r_state <= S_FETCH;
                    end else begin
                        r_x1    <= rel_x;
                        r_y1    <= ry_nudged;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_p1    <= r_x0 * r_y1;
                    r_p2    <= r_x1 * r_y0;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_odd <= r_odd ^ toggle;
                    r_x0  <= r_x1;
                    r_y0  <= r_y1;
                    if (r_idx == last_idx) begin
                        o_inside_res   <= r_odd ^ toggle;
                        o_store_full   <= 1'b0;
                        o_too_few      <= 1'b0;
                        o_vertex_total <= TOTAL_W'(r_count);
                        o_valid        <= 1'b1;
                        r_state        <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= S_FETCH;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> dv/point_in_polygon_test_tb.sv
`timescale 1ns / 100ps

module point_in_polygon_test_tb
    import pip_pkg::*;
;

    localparam int MAX_VERT   = 64;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] x;
        logic [31:0] y;
    } t_item;

    typedef struct packed {
        logic       in_poly;
        logic [6:0] total;
        logic       full;
        logic       few;
    } t_answer;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [1:0]        i_cmd;
    logic signed [31:0] i_coord_x;
    logic signed [31:0] i_coord_y;
    logic              o_valid;
    logic              i_ready;
    logic              o_inside_res;
    logic [6:0]        o_vertex_total;
    logic              o_store_full;
    logic              o_too_few;
    logic              i_cfg_we;
    logic [15:0]       i_cfg_wdata;
    logic              o_ready_q;

    t_item   pending_items[$];
    t_answer expected_answers[$];
    int      error_count;
    int      idle_cycles;
    int      burst_left;
    int      gap_left;
    int      stall_phase;

    // polygon model state
    logic signed [31:0] poly_x[MAX_VERT];
    logic signed [31:0] poly_y[MAX_VERT];
    int                 poly_count;
    logic [15:0]        eps_model;

    point_in_polygon_test #(
        .MAX_VERTICES(64),
        .COORD_WIDTH (32)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_inside_res  (o_inside_res),
        .o_vertex_total(o_vertex_total),
        .o_store_full  (o_store_full),
        .o_too_few     (o_too_few),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic longint nudged(longint ry);
        longint mag;
        mag = (ry < 0) ? -ry : ry;
        return (mag < longint'(eps_model)) ? -longint'(eps_model) : ry;
    endfunction

    // crossing-number parity of the stored polygon around a point
    function automatic logic crossing_parity(longint qx, longint qy);
        longint          x0, y0, x1, y1;
        logic signed [127:0] p1, p2;
        logic            odd;
        int              c;
        odd = 1'b0;
        x0 = longint'(poly_x[poly_count-1]) - qx;
        y0 = nudged(longint'(poly_y[poly_count-1]) - qy);
        for (int i = 0; i < poly_count; i++) begin
            x1 = longint'(poly_x[i]) - qx;
            y1 = nudged(longint'(poly_y[i]) - qy);
            if ((y0 < 0 && y1 > 0) || (y0 > 0 && y1 < 0)) begin
                if (x0 > 0 && x1 > 0) begin
                    odd = !odd;
                end else if (x0 > 0 || x1 > 0) begin
                    p1 = 128'(signed'(x0)) * 128'(signed'(y1));
                    p2 = 128'(signed'(x1)) * 128'(signed'(y0));
                    c = (p1 > p2) ? 1 : ((p1 < p2) ? -1 : 0);
                    if ((y1 > y0 && c > 0) || (y1 < y0 && c < 0))
                        odd = !odd;
                end
            end
            x0 = x1;
            y0 = y1;
        end
        return odd;
    endfunction

    function automatic t_answer polygon_step(t_item it);
        t_answer a;
        a = '0;
        case (t_cmd'(it.cmd))
            CMD_CLEAR: poly_count = 0;
            CMD_APPEND: begin
                if (poly_count < MAX_VERT) begin
                    poly_x[poly_count] = it.x;
                    poly_y[poly_count] = it.y;
                    poly_count++;
                end else begin
                    a.full = 1'b1;
                end
            end
            CMD_QUERY: begin
                if (poly_count < 3)
                    a.few = 1'b1;
                else
                    a.in_poly = crossing_parity(longint'(signed'(it.x)),
                                                longint'(signed'(it.y)));
            end
            default: ;
        endcase
        a.total = 7'(poly_count);
        return a;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // driver: bursts with random gaps
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready_q) begin
                void'(pending_items.pop_front());
            end
            if (!(i_valid && !o_ready_q)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if (pending_items.size() > 0 && !(i_valid && o_ready_q &&
                             pending_items.size() == 0)) begin
                    i_valid <= 1'b1;
                    i_cmd <= pending_items[0].cmd;
                    i_coord_x <= pending_items[0].x;
                    i_coord_y <= pending_items[0].y;
                    if (burst_left <= 0) begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // input acceptance seen at the rising edge
    always @(posedge i_clk) begin
        o_ready_q <= o_ready;
        if (i_rst_n && i_valid && o_ready)
            expected_answers.insert(expected_answers.size(),
                                    polygon_step(pending_items[0]));
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase[9])
            i_ready <= 1'b1;
        else
            i_ready <= ($urandom_range(0, 3) != 0);
    end

    // monitor
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_answers.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                want = expected_answers.pop_front();
                if (o_inside_res !== want.in_poly)
                    report_mismatch("inside_res", o_inside_res, want.in_poly);
                if (o_vertex_total !== want.total)
                    report_mismatch("vertex_total", o_vertex_total, want.total);
                if (o_store_full !== want.full)
                    report_mismatch("store_full", o_store_full, want.full);
                if (o_too_few !== want.few)
                    report_mismatch("too_few", o_too_few, want.few);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom;
            default: return 32'(signed'($urandom_range(0, 40)) - 20) <<< 16;
        endcase
    endfunction

    task automatic add_item(t_cmd c, logic [31:0] x, logic [31:0] y);
        t_item it;
        it.cmd = c;
        it.x = x;
        it.y = y;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic drain_and_set_eps(logic [15:0] value);
        wait (pending_items.size() == 0 && !i_valid);
        wait (expected_answers.size() == 0);
        repeat (300) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        eps_model = value;
    endtask

    // random polygon session: clear, append vertices, several queries or random commands
    task automatic add_session();
        int          nv;
        int          nq;
        logic [31:0] cx, cy;
        nv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 66) : $urandom_range(3, 10);
        add_item(CMD_CLEAR, $urandom, $urandom);
        cx = 32'(signed'($urandom_range(0, 8)) - 4) <<< 16;
        cy = 32'(signed'($urandom_range(0, 8)) - 4) <<< 16;
        for (int i = 0; i < nv; i++) begin
            if ($urandom_range(0, 4) == 0)
                add_item(CMD_APPEND, rand_coord(), rand_coord());
            else
                add_item(CMD_APPEND, cx + (32'(signed'($urandom_range(0, 20)) - 10) <<< 15),
                         cy + (32'(signed'($urandom_range(0, 20)) - 10) <<< 15));
        end
        nq = $urandom_range(2, 8);
        for (int i = 0; i < nq; i++) begin
            if ($urandom_range(0, 9) == 0)
                add_item(t_cmd'($urandom_range(0, 3)), rand_coord(), rand_coord());
            else if ($urandom_range(0, 3) == 0)
                add_item(CMD_QUERY, rand_coord(), rand_coord());
            else
                add_item(CMD_QUERY, cx + (32'(signed'($urandom_range(0, 24)) - 12) <<< 15)
                         + $urandom_range(0, 3), cy
                         + (32'(signed'($urandom_range(0, 24)) - 12) <<< 15));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cmd = CMD_CLEAR;
        i_coord_x = '0;
        i_coord_y = '0;
        i_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        error_count = 0;
        idle_cycles = 0;
        burst_left = 0;
        gap_left = 0;
        stall_phase = 0;
        o_ready_q = 1'b0;
        poly_count = 0;
        eps_model = EPS_RESET;
        for (int i = 0; i < MAX_VERT; i++) begin
            poly_x[i] = '0;
            poly_y[i] = '0;
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: too few, unit square, vertex on ray, unused command, extremes, store overflow
        add_item(CMD_QUERY, 32'h0, 32'h0);
        add_item(CMD_APPEND, 32'h0, 32'h0);
        add_item(CMD_APPEND, 32'h0001_0000, 32'h0);
        add_item(CMD_QUERY, 32'h0, 32'h0);
        add_item(CMD_APPEND, 32'h0001_0000, 32'h0001_0000);
        add_item(CMD_APPEND, 32'h0, 32'h0001_0000);
        add_item(CMD_QUERY, 32'h0000_8000, 32'h0000_8000);
        add_item(CMD_QUERY, 32'h0002_0000, 32'h0000_8000);
        add_item(CMD_QUERY, 32'hffff_8000, 32'h0000_8000);
        add_item(CMD_QUERY, 32'h0000_8000, 32'h0);
        add_item(CMD_NONE, 32'hffff_ffff, 32'hffff_ffff);
        add_item(CMD_CLEAR, 32'h0, 32'h0);
        add_item(CMD_APPEND, 32'h8000_0000, 32'h8000_0000);
        add_item(CMD_APPEND, 32'h7fff_ffff, 32'h8000_0000);
        add_item(CMD_APPEND, 32'h7fff_ffff, 32'h7fff_ffff);
        add_item(CMD_APPEND, 32'h8000_0000, 32'h7fff_ffff);
        add_item(CMD_QUERY, 32'h0, 32'h0);
        add_item(CMD_QUERY, 32'h7fff_ffff, 32'h8000_0000);
        add_item(CMD_QUERY, 32'h8000_0000, 32'h7fff_ffff);
        add_item(CMD_CLEAR, 32'h0, 32'h0);
        for (int i = 0; i < 65; i++)
            add_item(CMD_APPEND, 32'(i) <<< 16, (i % 2) ? 32'h0001_0000 : 32'hffff_0000);
        add_item(CMD_QUERY, 32'h0000_8000, 32'h0);

        // random phases across tolerance settings
        drain_and_set_eps(16'd0);
        while (pending_items.size() < 1000 && expected_answers.size() < 2000) begin
            add_session();
            if (pending_items.size() > 300) break;
        end
        drain_and_set_eps(16'hffff);
        for (int i = 0; i < 24; i++) add_session();
        drain_and_set_eps(16'($urandom));
        for (int i = 0; i < 24; i++) add_session();
        drain_and_set_eps(EPS_RESET);
        for (int i = 0; i < 24; i++) add_session();

        wait (pending_items.size() == 0 && !i_valid);
        wait (expected_answers.size() == 0);
        repeat (300) @(posedge i_clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> point_in_polygon_test.f
sv/pip_pkg.sv
sv/pip_ram.sv
sv/pip_front.sv
sv/pip_back.sv
sv/point_in_polygon_test.sv
dv/point_in_polygon_test_tb.sv
